FILE: src/occg_pkg.sv
// Shared constants, codes and control types of the occupancy grid inflation block.
`default_nettype none
package occg_pkg;

  localparam int MAX_COLS        = 64;
  localparam int MAX_ROWS        = 64;
  localparam int MAX_CELL_RADIUS = 8;
  localparam int SAFETY_MARGIN   = 48;

  localparam int CI_W   = $clog2(MAX_COLS);
  localparam int RI_W   = $clog2(MAX_ROWS);
  localparam int ADDR_W = CI_W + RI_W;
  localparam int DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int GC_W   = $clog2(MAX_COLS + 1);
  localparam int GR_W   = $clog2(MAX_ROWS + 1);
  localparam int RAD_W  = $clog2(MAX_CELL_RADIUS + 1);
  // Signed cell index, holds a window that hangs over the grid edge.
  localparam int SW     = 10;
  // Accumulators of the repeated-addition quotient loops.
  localparam int ACC_W  = 20;
  // Doubled world coordinates of cell centres and distances.
  localparam int CW     = 26;
  localparam int CNT_W  = 13;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_WALLS  = 3'd1,
    CMD_HIT    = 3'd2,
    CMD_CIRCLE = 3'd3,
    CMD_RECT   = 3'd4,
    CMD_QUERY  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_CELL_SIZE    = 3'd0,
    CFG_ARENA_X      = 3'd1,
    CFG_ARENA_Y      = 3'd2,
    CFG_ARENA_WIDTH  = 3'd3,
    CFG_ARENA_HEIGHT = 3'd4,
    CFG_ROBOT_RADIUS = 3'd5,
    CFG_MAX_RANGE    = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SIZE,
    ST_CLEAR,
    ST_HINIT,
    ST_HDIV,
    ST_LIM,
    ST_C0,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_QRD,
    ST_QCAP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic size_init;
    logic size_run;
    logic grid_load;
    logic clr_init;
    logic clr_run;
    logic hit_init;
    logic hit_run;
    logic set_hit;
    logic lim_load;
    logic c0;
    logic c1;
    logic c2;
    logic c3;
    logic q_read;
    logic q_cap;
    logic res_load;
  } dp_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       size_done;
    logic       size_diff;
    logic       clr_done;
    logic       range_ok;
    logic       hit_done;
    logic       hit_in;
    logic       grid_empty;
    logic       cell_last;
    logic       out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

FILE: src/occg_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module occg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: src/occg_datapath.sv
// Datapath: configuration, grid sizing loops, cell geometry, occupancy memory and results.
`default_nettype none
module occg_datapath import occg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic [2:0]         command,
  input  wire logic signed [15:0] point_x,
  input  wire logic signed [15:0] point_y,
  input  wire logic [15:0]        hit_range,
  input  wire logic [13:0]        obstacle_radius,
  input  wire logic [14:0]        obstacle_width,
  input  wire logic [14:0]        obstacle_height,
  input  wire logic signed [7:0]  query_col,
  input  wire logic signed [7:0]  query_row,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    blocked_flag,
  output logic                    hit_in_grid,
  output logic [CNT_W-1:0]        cells_marked,
  input  wire dp_ctl_t            ctl,
  output dp_sts_t                 sts
);

  // Configuration registers.
  logic [11:0]        cell_size;
  logic signed [15:0] arena_x;
  logic signed [15:0] arena_y;
  logic [14:0]        arena_width;
  logic [14:0]        arena_height;
  logic [13:0]        robot_radius;
  logic [15:0]        max_lidar_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size       <= 12'd160;
      arena_x         <= '0;
      arena_y         <= '0;
      arena_width     <= 15'd10240;
      arena_height    <= 15'd10240;
      robot_radius    <= 14'd160;
      max_lidar_range <= 16'd32000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CELL_SIZE:    cell_size       <= cfg_data[11:0];
        CFG_ARENA_X:      arena_x         <= $signed(cfg_data);
        CFG_ARENA_Y:      arena_y         <= $signed(cfg_data);
        CFG_ARENA_WIDTH:  arena_width     <= cfg_data[14:0];
        CFG_ARENA_HEIGHT: arena_height    <= cfg_data[14:0];
        CFG_ROBOT_RADIUS: robot_radius    <= cfg_data[13:0];
        CFG_MAX_RANGE:    max_lidar_range <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [11:0] cs_eff;
  logic [14:0] clr;
  logic [15:0] clr2;
  assign cs_eff = (cell_size == 12'd0) ? 12'd1 : cell_size;
  assign clr    = 15'(robot_radius) + 15'(SAFETY_MARGIN);
  assign clr2   = {clr, 1'b0};

  // Captured transaction.
  logic [2:0]         cmd_r;
  logic signed [15:0] px_r;
  logic signed [15:0] py_r;
  logic [15:0]        rng_r;
  logic [13:0]        orad_r;
  logic [14:0]        ow_r;
  logic [14:0]        oh_r;
  logic signed [7:0]  qc_r;
  logic signed [7:0]  qr_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_r <= CMD_CLEAR;
    end else if (ctl.take) begin
      cmd_r <= command;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      px_r   <= point_x;
      py_r   <= point_y;
      rng_r  <= hit_range;
      orad_r <= obstacle_radius;
      ow_r   <= obstacle_width;
      oh_r   <= obstacle_height;
      qc_r   <= query_col;
      qr_r   <= query_row;
    end
  end

  // Grid sizing: ceil(size / cell) by repeated addition, saturated at the maximum.
  logic [ACC_W-1:0] sacc_c, sacc_r;
  logic [GC_W-1:0]  sn_c, grid_cols;
  logic [GR_W-1:0]  sn_r, grid_rows;
  logic             sstop_c, sstop_r;

  assign sstop_c = (sn_c == GC_W'(MAX_COLS)) || (sacc_c >= ACC_W'(arena_width));
  assign sstop_r = (sn_r == GR_W'(MAX_ROWS)) || (sacc_r >= ACC_W'(arena_height));

  always_ff @(posedge clk) begin
    if (rst || ctl.size_init) begin
      sacc_c <= '0;
      sacc_r <= '0;
      sn_c   <= '0;
      sn_r   <= '0;
    end else if (ctl.size_run) begin
      if (!sstop_c) begin
        sacc_c <= sacc_c + ACC_W'(cs_eff);
        sn_c   <= sn_c + 1'b1;
      end
      if (!sstop_r) begin
        sacc_r <= sacc_r + ACC_W'(cs_eff);
        sn_r   <= sn_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= '0;
      grid_rows <= '0;
    end else if (ctl.grid_load) begin
      grid_cols <= sn_c;
      grid_rows <= sn_r;
    end
  end

  // Clearing sweep.
  logic [ADDR_W-1:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst || ctl.clr_init) begin
      clr_cnt <= '0;
    end else if (ctl.clr_run) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Hit cell and window radius, each a short quotient loop.
  logic signed [16:0] hdx, hdy;
  logic [7:0]         hq_c, hq_r;
  logic [ACC_W-1:0]   hacc_c, hacc_r, racc;
  logic [RAD_W-1:0]   rq;
  logic               hstop_c, hstop_r, rstop;

  assign hdx = 17'(px_r) - 17'(arena_x);
  assign hdy = 17'(py_r) - 17'(arena_y);

  assign hstop_c = hdx[16] || (hacc_c > ACC_W'(hdx[15:0])) || (hq_c > 8'(grid_cols));
  assign hstop_r = hdy[16] || (hacc_r > ACC_W'(hdy[15:0])) || (hq_r > 8'(grid_rows));
  assign rstop   = (racc >= ACC_W'(clr)) || (rq == RAD_W'(MAX_CELL_RADIUS));

  always_ff @(posedge clk) begin
    if (ctl.hit_init) begin
      hq_c   <= '0;
      hq_r   <= '0;
      hacc_c <= ACC_W'(cs_eff);
      hacc_r <= ACC_W'(cs_eff);
      rq     <= '0;
      racc   <= '0;
    end else if (ctl.hit_run) begin
      if (!hstop_c) begin
        hq_c   <= hq_c + 1'b1;
        hacc_c <= hacc_c + ACC_W'(cs_eff);
      end
      if (!hstop_r) begin
        hq_r   <= hq_r + 1'b1;
        hacc_r <= hacc_r + ACC_W'(cs_eff);
      end
      if (!rstop) begin
        rq   <= rq + 1'b1;
        racc <= racc + ACC_W'(cs_eff);
      end
    end
  end

  logic signed [SW-1:0] gc_s, gr_s, hc, hr, rad_s;
  logic                 hin_c, hin_r;
  assign gc_s  = SW'(grid_cols);
  assign gr_s  = SW'(grid_rows);
  assign rad_s = SW'(rq);
  // A hit exactly on the far edge belongs to the last cell.
  assign hc    = (hq_c == 8'(grid_cols)) ? gc_s - SW'(1) : SW'(hq_c);
  assign hr    = (hq_r == 8'(grid_rows)) ? gr_s - SW'(1) : SW'(hq_r);
  assign hin_c = !hdx[16] && ((hq_c < 8'(grid_cols)) ||
                 ((hq_c == 8'(grid_cols)) && (grid_cols != '0)));
  assign hin_r = !hdy[16] && ((hq_r < 8'(grid_rows)) ||
                 ((hq_r == 8'(grid_rows)) && (grid_rows != '0)));

  // Cell iteration bounds and the squared distance limit.
  logic signed [SW-1:0] ci, ri, chi, rlo, rhi;
  logic [17:0]          lim_base;
  logic [35:0]          lim;

  assign lim_base = (cmd_r == CMD_CIRCLE) ? (18'({orad_r, 1'b0}) + 18'(clr2)) : 18'(clr2);

  always_ff @(posedge clk) begin
    if (ctl.lim_load) begin
      lim <= lim_base * lim_base;
      if (cmd_r == CMD_HIT) begin
        chi <= hc + rad_s;
        rlo <= hr - rad_s;
        rhi <= hr + rad_s;
        ci  <= hc - rad_s;
        ri  <= hr - rad_s;
      end else begin
        chi <= gc_s - SW'(1);
        rlo <= '0;
        rhi <= gr_s - SW'(1);
        ci  <= '0;
        ri  <= '0;
      end
    end else if (ctl.c3) begin
      if (ri == rhi) begin
        ri <= rlo;
        ci <= ci + SW'(1);
      end else begin
        ri <= ri + SW'(1);
      end
    end
  end

  // Cell geometry pipeline, one stage per step of the controller.
  logic signed [SW:0]     ci_odd, ri_odd;
  logic signed [12:0]     cs_s;
  logic signed [CW-1:0]   ax2, ay2, xe, ye, px2, py2, clr2_s, ow_s, oh_s;
  logic signed [CW-1:0]   cx, cy, dx, dy, clx, cly;
  logic signed [2*CW-1:0] sqx, sqy, lim_s;
  logic                   inb, old, wall, mark_hit;

  assign ci_odd = {ci, 1'b1};
  assign ri_odd = {ri, 1'b1};
  assign cs_s   = 13'(cs_eff);
  assign ax2    = CW'($signed({arena_x, 1'b0}));
  assign ay2    = CW'($signed({arena_y, 1'b0}));
  assign xe     = ax2 + CW'({arena_width, 1'b0});
  assign ye     = ay2 + CW'({arena_height, 1'b0});
  assign px2    = CW'($signed({px_r, 1'b0}));
  assign py2    = CW'($signed({py_r, 1'b0}));
  assign clr2_s = CW'(clr2);
  assign ow_s   = CW'(ow_r);
  assign oh_s   = CW'(oh_r);
  assign lim_s  = (2*CW)'(lim);

  // Nearest point of the rectangle to the cell centre.
  assign clx = (cx < px2 - ow_s) ? px2 - ow_s : ((cx > px2 + ow_s) ? px2 + ow_s : cx);
  assign cly = (cy < py2 - oh_s) ? py2 - oh_s : ((cy > py2 + oh_s) ? py2 + oh_s : cy);

  logic ram_rdata;

  always_ff @(posedge clk) begin
    if (ctl.c0) begin
      cx  <= ax2 + CW'(ci_odd * cs_s);
      cy  <= ay2 + CW'(ri_odd * cs_s);
      inb <= (ci >= 0) && (ci < gc_s) && (ri >= 0) && (ri < gr_s);
    end
    if (ctl.c1) begin
      old  <= ram_rdata;
      dx   <= (cmd_r == CMD_RECT) ? cx - clx : cx - px2;
      dy   <= (cmd_r == CMD_RECT) ? cy - cly : cy - py2;
      wall <= (cx - clr2_s < ax2) || (cx + clr2_s > xe) ||
              (cy - clr2_s < ay2) || (cy + clr2_s > ye);
    end
    if (ctl.c2) begin
      sqx <= dx * dx;
      sqy <= dy * dy;
    end
  end

  assign mark_hit = (cmd_r == CMD_WALLS) ? wall : ((sqx + sqy) < lim_s);

  // Occupancy memory port.
  logic              ram_we, ram_wdata, q_in;
  logic [ADDR_W-1:0] ram_addr, cell_addr, q_addr;

  assign cell_addr = ADDR_W'(int'(ci[CI_W-1:0]) * MAX_ROWS + int'(ri[RI_W-1:0]));
  assign q_addr    = ADDR_W'(int'(qc_r[CI_W-1:0]) * MAX_ROWS + int'(qr_r[RI_W-1:0]));
  assign q_in      = (qc_r >= 0) && (SW'(qc_r) < gc_s) && (qr_r >= 0) && (SW'(qr_r) < gr_s);

  always_comb begin
    ram_addr  = cell_addr;
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    if (ctl.clr_run) begin
      ram_addr = clr_cnt;
      ram_we   = 1'b1;
    end else if (ctl.q_read) begin
      ram_addr = q_addr;
    end else if (ctl.c3) begin
      ram_we    = inb && mark_hit;
      ram_wdata = 1'b1;
    end
  end

  occg_ram #(
    .WIDTH(1),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Result of the transaction in progress.
  logic             blocked, in_grid;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst || ctl.take) begin
      blocked <= 1'b0;
      in_grid <= 1'b0;
      count   <= '0;
    end else begin
      if (ctl.q_cap) begin
        blocked <= q_in ? ram_rdata : 1'b1;
      end
      if (ctl.set_hit) begin
        in_grid <= 1'b1;
      end
      if (ctl.c3 && inb && mark_hit && !old) begin
        count <= count + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      blocked_flag <= blocked;
      hit_in_grid  <= in_grid;
      cells_marked <= count;
    end
  end

  assign sts.cmd        = cmd_r;
  assign sts.size_done  = sstop_c && sstop_r;
  assign sts.size_diff  = (sn_c != grid_cols) || (sn_r != grid_rows);
  assign sts.clr_done   = (clr_cnt == ADDR_W'(DEPTH - 1));
  assign sts.range_ok   = (rng_r < max_lidar_range);
  assign sts.hit_done   = hstop_c && hstop_r && rstop;
  assign sts.hit_in     = hin_c && hin_r;
  assign sts.grid_empty = (grid_cols == '0) || (grid_rows == '0);
  assign sts.cell_last  = (ci == chi) && (ri == rhi);
  assign sts.out_free   = !out_valid || out_ready;

  a_we_only_in_sweep: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (ctl.clr_run || ctl.c3))
    else $error("occupancy write outside a clearing or marking step");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (rst)
    ctl.res_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

  a_count_only_on_mark: assert property (@(posedge clk) disable iff (rst)
    (!ctl.c3 && !ctl.take) |=> $stable(count))
    else $error("marked count changed outside a marking step");

endmodule
`default_nettype wire

FILE: src/occg_ctrl.sv
// Controller state machine that sequences sizing, clearing, marking and queries.
`default_nettype none
module occg_ctrl import occg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] command,
  input  wire dp_sts_t    sts,
  output dp_ctl_t         ctl
);

  state_t state, state_next;
  state_t post_state;
  logic   boot;
  logic   need_clear;

  // After reset the grid is sized and swept once before any transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SIZE;
      boot  <= 1'b1;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR && sts.clr_done) begin
        boot <= 1'b0;
      end
    end
  end

  assign need_clear = boot || (sts.cmd == CMD_CLEAR) || (sts.cmd == CMD_WALLS) ||
                      sts.size_diff;

  always_comb begin
    post_state = ST_DONE;
    if (boot) begin
      post_state = ST_IDLE;
    end else begin
      case (sts.cmd)
        CMD_WALLS, CMD_CIRCLE, CMD_RECT: post_state = ST_LIM;
        CMD_HIT:   post_state = sts.range_ok ? ST_HINIT : ST_DONE;
        default:   post_state = ST_DONE;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (command == CMD_QUERY) begin
            state_next = ST_QRD;
          end else if (command <= CMD_RECT) begin
            state_next = ST_SIZE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SIZE: begin
        if (sts.size_done) begin
          state_next = need_clear ? ST_CLEAR : post_state;
        end
      end
      ST_CLEAR: begin
        if (sts.clr_done) begin
          state_next = post_state;
        end
      end
      ST_HINIT: state_next = ST_HDIV;
      ST_HDIV: begin
        if (sts.hit_done) begin
          state_next = sts.hit_in ? ST_LIM : ST_DONE;
        end
      end
      ST_LIM: begin
        state_next = (sts.cmd != CMD_HIT && sts.grid_empty) ? ST_DONE : ST_C0;
      end
      ST_C0:   state_next = ST_C1;
      ST_C1:   state_next = ST_C2;
      ST_C2:   state_next = ST_C3;
      ST_C3:   state_next = sts.cell_last ? ST_DONE : ST_C0;
      ST_QRD:  state_next = ST_QCAP;
      ST_QCAP: state_next = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        ctl.take      = in_valid;
        ctl.size_init = in_valid;
      end
      ST_SIZE: begin
        ctl.size_run = 1'b1;
        if (sts.size_done && need_clear) begin
          ctl.grid_load = 1'b1;
          ctl.clr_init  = 1'b1;
        end
      end
      ST_CLEAR: ctl.clr_run  = 1'b1;
      ST_HINIT: ctl.hit_init = 1'b1;
      ST_HDIV: begin
        ctl.hit_run = 1'b1;
        ctl.set_hit = sts.hit_done && sts.hit_in;
      end
      ST_LIM:  ctl.lim_load = 1'b1;
      ST_C0:   ctl.c0 = 1'b1;
      ST_C1:   ctl.c1 = 1'b1;
      ST_C2:   ctl.c2 = 1'b1;
      ST_C3:   ctl.c3 = 1'b1;
      ST_QRD:  ctl.q_read = 1'b1;
      ST_QCAP: ctl.q_cap = 1'b1;
      ST_DONE: ctl.res_load = sts.out_free;
      default: ;
    endcase
  end

  a_c3_follows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_C3) |=> (state == ST_C0 || state == ST_DONE))
    else $error("cell step did not advance");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.take |=> (state != ST_IDLE))
    else $error("transaction taken without leaving idle");

  a_one_mem_use: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.clr_run, ctl.q_read, ctl.c3}))
    else $error("two users of the grid memory at once");

endmodule
`default_nettype wire

FILE: src/occupancy_grid_inflation_top.sv
// Top level of the occupancy grid with obstacle inflation.
//
// Input channel (in_valid/in_ready) carries one command per transaction:
// clear, clear with walls, lidar hit, circle, rectangle or query. Every
// accepted transaction returns exactly one result on the output channel
// (out_valid/out_ready): blocked_flag, hit_in_grid and cells_marked.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data,
// by the user only while the block is idle; the block does not check this.
// One transaction is in work at a time. A query reads the memory and then
// captures the addressed cell. Clear runs the sizing loop and then sweeps
// all 4096 memory entries. Walls, circle and rectangle pass every grid cell
// through the four-step cell pipeline; a lidar hit first searches for its
// cell and then passes each cell of its window, at most 17 by 17 cells,
// through the same pipeline. The occupancy memory has a single port, so
// the sweep, the cell steps and the query never use it at once.
// After reset the grid is sized and the memory is swept clear, while
// in_ready stays low.
// A finished result sits in the output register; the next transaction is
// accepted while it waits, and its own result waits until the first is taken.
`default_nettype none
module occupancy_grid_inflation_top import occg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         command,
  input  wire logic signed [15:0] point_x,
  input  wire logic signed [15:0] point_y,
  input  wire logic [15:0]        hit_range,
  input  wire logic [13:0]        obstacle_radius,
  input  wire logic [14:0]        obstacle_width,
  input  wire logic [14:0]        obstacle_height,
  input  wire logic signed [7:0]  query_col,
  input  wire logic signed [7:0]  query_row,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    blocked_flag,
  output logic                    hit_in_grid,
  output logic [CNT_W-1:0]        cells_marked
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  occg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command (command),
    .sts     (sts),
    .ctl     (ctl)
  );

  occg_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .command        (command),
    .point_x        (point_x),
    .point_y        (point_y),
    .hit_range      (hit_range),
    .obstacle_radius(obstacle_radius),
    .obstacle_width (obstacle_width),
    .obstacle_height(obstacle_height),
    .query_col      (query_col),
    .query_row      (query_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .blocked_flag   (blocked_flag),
    .hit_in_grid    (hit_in_grid),
    .cells_marked   (cells_marked),
    .ctl            (ctl),
    .sts            (sts)
  );

endmodule
`default_nettype wire

FILE: dv/occupancy_grid_inflation_checker.sv
// Checker that predicts the occupancy grid results and compares them on the output channel.
module occupancy_grid_inflation_checker import occg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         command,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic [15:0]        hit_range,
  input  logic [13:0]        obstacle_radius,
  input  logic [14:0]        obstacle_width,
  input  logic [14:0]        obstacle_height,
  input  logic signed [7:0]  query_col,
  input  logic signed [7:0]  query_row,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               blocked_flag,
  input  logic               hit_in_grid,
  input  logic [CNT_W-1:0]   cells_marked,
  output int                 errors,
  output int                 pending,
  output int                 results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic             blocked;
    logic             in_grid;
    logic [CNT_W-1:0] marked;
  } grid_answer_t;

  logic [11:0]        cell_size;
  logic signed [15:0] org_x;
  logic signed [15:0] org_y;
  logic [14:0]        arena_w;
  logic [14:0]        arena_h;
  logic [13:0]        robot_r;
  logic [15:0]        range_max;

  bit occ [MAX_COLS][MAX_ROWS];
  int grid_cols;
  int grid_rows;
  int new_cells;
  grid_answer_t answer_q[$];

  function automatic longint cell_len();
    return (cell_size == 0) ? 1 : longint'(cell_size);
  endfunction

  function automatic int cells_over(longint len, int lim);
    longint n;
    n = (len + cell_len() - 1) / cell_len();
    return (n > lim) ? lim : int'(n);
  endfunction

  function automatic longint floor_quot(longint a, longint b);
    if (a >= 0) return a / b;
    return -((-a + b - 1) / b);
  endfunction

  // Cell centres are kept in doubled units so half a cell stays exact.
  function automatic longint centre_x2(int idx, longint origin);
    return 2 * origin + (2 * longint'(idx) + 1) * cell_len();
  endfunction

  function automatic void wipe_grid();
    foreach (occ[c, r]) occ[c][r] = 0;
    grid_cols = cells_over(longint'(arena_w), MAX_COLS);
    grid_rows = cells_over(longint'(arena_h), MAX_ROWS);
  endfunction

  function automatic void block_cell(int c, int r);
    if (!occ[c][r]) begin
      occ[c][r] = 1;
      new_cells++;
    end
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic grid_answer_t apply_command(logic [2:0] cmd, longint px, longint py,
                                                 longint rng, longint orad, longint ow,
                                                 longint oh, longint qc, longint qr);
    grid_answer_t ans;
    longint clr2, ax2, ay2, px2, py2, cs, cx, cy, dx, dy, lim, hc, hr, rad, tc, tr;
    ans = '{default: 0};
    new_cells = 0;
    cs = cell_len();
    clr2 = 2 * (longint'(robot_r) + SAFETY_MARGIN);
    ax2 = 2 * longint'(org_x);
    ay2 = 2 * longint'(org_y);
    px2 = 2 * px;
    py2 = 2 * py;
    if (cmd == CMD_CLEAR || cmd == CMD_WALLS) begin
      wipe_grid();
    end else if (cmd == CMD_HIT || cmd == CMD_CIRCLE || cmd == CMD_RECT) begin
      if (cells_over(longint'(arena_w), MAX_COLS) != grid_cols ||
          cells_over(longint'(arena_h), MAX_ROWS) != grid_rows)
        wipe_grid();
    end
    if (cmd == CMD_WALLS) begin
      for (int c = 0; c < grid_cols; c++)
        for (int r = 0; r < grid_rows; r++) begin
          cx = centre_x2(c, org_x);
          cy = centre_x2(r, org_y);
          if (cx - clr2 < ax2 || cx + clr2 > ax2 + 2 * longint'(arena_w) ||
              cy - clr2 < ay2 || cy + clr2 > ay2 + 2 * longint'(arena_h))
            block_cell(c, r);
        end
    end else if (cmd == CMD_HIT) begin
      if (rng < longint'(range_max)) begin
        hc = floor_quot(px - longint'(org_x), cs);
        hr = floor_quot(py - longint'(org_y), cs);
        if (hc == grid_cols) hc = grid_cols - 1;
        if (hr == grid_rows) hr = grid_rows - 1;
        if (hc >= 0 && hc < grid_cols && hr >= 0 && hr < grid_rows) begin
          ans.in_grid = 1;
          rad = (clr2 / 2 + cs - 1) / cs;
          if (rad > MAX_CELL_RADIUS) rad = MAX_CELL_RADIUS;
          lim = clr2 * clr2;
          for (longint dc = -rad; dc <= rad; dc++)
            for (longint dr = -rad; dr <= rad; dr++) begin
              tc = hc + dc;
              tr = hr + dr;
              if (tc >= 0 && tc < grid_cols && tr >= 0 && tr < grid_rows) begin
                dx = centre_x2(int'(tc), org_x) - px2;
                dy = centre_x2(int'(tr), org_y) - py2;
                if (dx * dx + dy * dy < lim) block_cell(int'(tc), int'(tr));
              end
            end
        end
      end
    end else if (cmd == CMD_CIRCLE || cmd == CMD_RECT) begin
      for (int c = 0; c < grid_cols; c++)
        for (int r = 0; r < grid_rows; r++) begin
          cx = centre_x2(c, org_x);
          cy = centre_x2(r, org_y);
          if (cmd == CMD_CIRCLE) begin
            dx = cx - px2;
            dy = cy - py2;
            lim = (2 * orad + clr2) * (2 * orad + clr2);
          end else begin
            dx = cx - clamp_to(cx, px2 - ow, px2 + ow);
            dy = cy - clamp_to(cy, py2 - oh, py2 + oh);
            lim = clr2 * clr2;
          end
          if (dx * dx + dy * dy < lim) block_cell(c, r);
        end
    end else if (cmd == CMD_QUERY) begin
      if (qc < 0 || qc >= grid_cols || qr < 0 || qr >= grid_rows)
        ans.blocked = 1;
      else
        ans.blocked = occ[qc][qr];
    end
    ans.marked = new_cells[CNT_W-1:0];
    return ans;
  endfunction

  always @(posedge clk) begin
    grid_answer_t exp_a;
    if (rst) begin
      cell_size = 160;
      org_x = 0;
      org_y = 0;
      arena_w = 10240;
      arena_h = 10240;
      robot_r = 160;
      range_max = 32000;
      wipe_grid();
      answer_q.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_e'(cfg_index))
          CFG_CELL_SIZE:    cell_size = cfg_data[11:0];
          CFG_ARENA_X:      org_x = cfg_data;
          CFG_ARENA_Y:      org_y = cfg_data;
          CFG_ARENA_WIDTH:  arena_w = cfg_data[14:0];
          CFG_ARENA_HEIGHT: arena_h = cfg_data[14:0];
          CFG_ROBOT_RADIUS: robot_r = cfg_data[13:0];
          CFG_MAX_RANGE:    range_max = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        answer_q.push_back(apply_command(command, longint'(point_x), longint'(point_y),
                                         longint'(hit_range), longint'(obstacle_radius),
                                         longint'(obstacle_width), longint'(obstacle_height),
                                         longint'(query_col), longint'(query_row)));
      if (out_valid && out_ready) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          errors++;
          $display("%0t: result transaction with nothing expected", $time);
        end else begin
          exp_a = answer_q.pop_front();
          if (blocked_flag !== exp_a.blocked) begin
            errors++;
            $display("%0t: blocked_flag expected %0d actual %0d", $time, exp_a.blocked,
                     blocked_flag);
          end
          if (hit_in_grid !== exp_a.in_grid) begin
            errors++;
            $display("%0t: hit_in_grid expected %0d actual %0d", $time, exp_a.in_grid,
                     hit_in_grid);
          end
          if (cells_marked !== exp_a.marked) begin
            errors++;
            $display("%0t: cells_marked expected %0d actual %0d", $time, exp_a.marked,
                     cells_marked);
          end
        end
      end
    end
    pending = answer_q.size();
  end

endmodule

FILE: dv/occupancy_grid_inflation_top_tb.sv
// Stimulus, clocking and verdict for the occupancy grid inflation testbench.
module occupancy_grid_inflation_top_tb;
  import occg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_wr_en = 0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [2:0]         command = '0;
  logic signed [15:0] point_x = '0;
  logic signed [15:0] point_y = '0;
  logic [15:0]        hit_range = '0;
  logic [13:0]        obstacle_radius = '0;
  logic [14:0]        obstacle_width = '0;
  logic [14:0]        obstacle_height = '0;
  logic signed [7:0]  query_col = '0;
  logic signed [7:0]  query_row = '0;
  logic               out_valid;
  logic               out_ready = 0;
  logic               blocked_flag;
  logic               hit_in_grid;
  logic [CNT_W-1:0]   cells_marked;

  int  errors, pending, results_seen;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_req = 0;
  int  cycle_count = 0;
  int  items_sent = 0;
  // Stimulus-side copy of the settings, used only to aim points, queries, ranges and obstacle sizes.
  int  t_cs = 160, t_ax = 0, t_ay = 0, t_w = 10240, t_h = 10240, t_rr = 160, t_mr = 32000;

  occupancy_grid_inflation_top dut (.*);

  occupancy_grid_inflation_checker checker_i (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 60000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 0;
        repeat (600) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic int sat16(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic int grid_dim(int len);
    int n;
    n = (len + t_cs - 1) / t_cs;
    return (n > 64) ? 64 : n;
  endfunction

  task automatic send_item(cmd_e cmd, int px, int py, int rng, int orad, int ow, int oh,
                           int qc, int qr);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    command <= cmd;
    point_x <= px[15:0];
    point_y <= py[15:0];
    hit_range <= rng[15:0];
    obstacle_radius <= orad[13:0];
    obstacle_width <= ow[14:0];
    obstacle_height <= oh[14:0];
    query_col <= qc[7:0];
    query_row <= qr[7:0];
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    @(posedge clk);
  endtask

  task automatic load_settings(int cs, int ax, int ay, int w, int h, int rr, int mr);
    t_cs = cs; t_ax = ax; t_ay = ay; t_w = w; t_h = h; t_rr = rr; t_mr = mr;
    write_reg(CFG_CELL_SIZE, cs);
    write_reg(CFG_ARENA_X, ax);
    write_reg(CFG_ARENA_Y, ay);
    write_reg(CFG_ARENA_WIDTH, w);
    write_reg(CFG_ARENA_HEIGHT, h);
    write_reg(CFG_ROBOT_RADIUS, rr);
    write_reg(CFG_MAX_RANGE, mr);
    cfg_wr_en <= 0;
    @(posedge clk);
  endtask

  task automatic random_item();
    int sel, px, py, rng, orad, ow, oh, qc, qr, cols, rows;
    cmd_e cmd;
    cols = grid_dim(t_w);
    rows = grid_dim(t_h);
    sel = $urandom_range(99);
    cmd = (sel < 2) ? CMD_CLEAR : (sel < 4) ? CMD_WALLS : (sel < 40) ? CMD_HIT :
          (sel < 50) ? CMD_CIRCLE : (sel < 60) ? CMD_RECT : CMD_QUERY;
    px = sat16(t_ax + $urandom_range(0, t_w + 2 * t_cs) - t_cs);
    py = sat16(t_ay + $urandom_range(0, t_h + 2 * t_cs) - t_cs);
    rng = (t_mr > 0) ? $urandom_range(0, t_mr - 1) : 0;
    if ($urandom_range(4) == 0) rng = $urandom_range(t_mr, 65535);
    orad = $urandom_range(0, 2 * t_cs) % 16384;
    ow = $urandom_range(0, 3 * t_cs) % 32768;
    oh = $urandom_range(0, 3 * t_cs) % 32768;
    qc = $urandom_range(0, cols + 1) - 1;
    qr = $urandom_range(0, rows + 1) - 1;
    // A slice of pure noise so every field bit toggles.
    if ($urandom_range(9) == 0) begin
      px = $urandom; py = $urandom; rng = $urandom;
      orad = $urandom; ow = $urandom; oh = $urandom; qc = $urandom; qr = $urandom;
      px = sat16(px[15:0] - 32768 * 0 - (px[15] ? 65536 : 0));
      py = sat16(py[15:0] - (py[15] ? 65536 : 0));
    end
    send_item(cmd, px, py, rng, orad, ow, oh, qc, qr);
  endtask

  initial begin
    int cs, cols_t, rows_t, w, h;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part on the reset settings: full 64 by 64 grid.
    send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_WALLS, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 0, 0, 0, 32, 32);
    send_item(CMD_QUERY, 0, 0, 0, 0, 0, 0, -1, 0);
    send_item(CMD_QUERY, 0, 0, 0, 0, 0, 0, 64, 5);
    send_item(CMD_QUERY, 0, 0, 0, 0, 0, 0, 127, -128);
    send_item(CMD_QUERY, 0, 0, 0, 0, 0, 0, -128, 127);
    send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_HIT, 800, 800, 100, 0, 0, 0, 0, 0);
    send_item(CMD_HIT, 800, 800, 32000, 0, 0, 0, 0, 0);
    send_item(CMD_HIT, 900, 900, 65535, 0, 0, 0, 0, 0);
    // A hit exactly on the far arena edge lands in the last cell.
    send_item(CMD_HIT, 10240, 10240, 0, 0, 0, 0, 0, 0);
    send_item(CMD_HIT, -1, 0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_HIT, 32767, -32768, 0, 0, 0, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 0, 0, 0, 63, 63);
    send_item(CMD_CIRCLE, 5000, 5000, 0, 0, 0, 0, 0, 0);
    send_item(CMD_CIRCLE, 5000, 5000, 0, 16383, 0, 0, 0, 0);
    send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_RECT, 3000, 3000, 0, 0, 0, 0, 0, 0);
    send_item(CMD_RECT, -32768, 32767, 0, 0, 32767, 32767, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 0, 0, 0, 10, 10);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      if (ph == 0) begin
        // Smallest cell and tallest arena: a narrow strip of 8 by 64 cells.
        load_settings(1, 0, 0, 8, 32767, 0, 65535);
      end else if (ph == 1) begin
        load_settings(4095, -32768, 32767, 32767, 1, 16383, 0);
      end else if (ph == 2) begin
        load_settings(4095, 32767, -32768, 32767, 32767, 16383, 65535);
      end else begin
        cs = $urandom_range(16, 4095);
        cols_t = $urandom_range(1, 12);
        rows_t = $urandom_range(1, 12);
        w = cs * cols_t - $urandom_range(0, cs - 1);
        h = cs * rows_t - $urandom_range(0, cs - 1);
        if (w > 32767) w = 32767;
        if (h > 32767) h = 32767;
        load_settings(cs, $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                      w, h, $urandom_range(0, 2 * cs), $urandom_range(1000, 65535));
      end
      for (int i = 0; i < 210; i++) begin
        if (ph == 4 && i == 50) hold_req = 1;
        random_item();
      end
      drain();
    end

    repeat (50) @(posedge clk);
    $display("Covered %0d command transactions and %0d checked results over 10 settings,",
             items_sent, results_seen);
    $display("including extreme cell sizes, arena origins, clearances and lidar limits.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
